/* src/ihex_pkg.sv */
// types, codes and helpers for the intel hex record parser
// used by intel_hex_record_parser; no dependencies
package ihex_pkg;

    typedef enum logic [1:0] {
        KIND_DATA   = 2'd0,
        KIND_RECORD = 2'd1,
        KIND_FILE   = 2'd2,
        KIND_FAIL   = 2'd3
    } result_kind_t;

    typedef enum logic [3:0] {
        ERR_NONE      = 4'd0,
        ERR_BAD_START = 4'd1,
        ERR_NON_HEX   = 4'd2,
        ERR_LENGTH    = 4'd3,
        ERR_CHECKSUM  = 4'd4,
        ERR_BAD_TYPE  = 4'd5,
        ERR_AFTER_EOF = 4'd6,
        ERR_NO_EOF    = 4'd7,
        ERR_SHORT_EXT = 4'd8
    } error_code_t;

    localparam logic [7:0] CHAR_COLON   = 8'h3A;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

    localparam logic [7:0] REC_DATA    = 8'h00;
    localparam logic [7:0] REC_EOF     = 8'h01;
    localparam logic [7:0] REC_EXT_LIN = 8'h04;

    localparam logic [9:0] FIXED_CHARS = 10'd11;

    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
    localparam int unsigned CNT_W      = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        result_kind_t kind;
        logic [31:0]  addr;
        logic [7:0]   value;
        error_code_t  code;
        logic         last;
    } result_t;

    // bit 4 set when the character is a hex digit, bits 3..0 its value
    function automatic logic [4:0] hex_nibble(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h57)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        return r;
    endfunction

endpackage

/* src/intel_hex_record_parser.sv */
// intel hex record parser: one character per transaction, records checked in a single pass
// the results of a character are written into the result queue on acceptance and offered from its head
// throughput: one character per cycle while each yields at most one result and the output
// is not stalled; a character with two results uses two output transactions, absorbed by a four-entry result queue
// reset: asynchronous, clears parser state, sticky failure and the result queue
// depends on ihex_pkg
module intel_hex_record_parser
    import ihex_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  char_code,
    input  logic        end_of_input,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  result_kind,
    output logic [31:0] byte_address,
    output logic [7:0]  byte_value,
    output logic [3:0]  error_code,
    output logic        last_of_run
);

    logic [9:0]  pos_reg,   pos_next;
    logic [3:0]  pend_reg,  pend_next;
    logic [7:0]  cnt_reg,   cnt_next;
    logic [15:0] raddr_reg, raddr_next;
    logic [7:0]  rtype_reg, rtype_next;
    logic [7:0]  sum_reg,   sum_next;
    logic [15:0] upper_reg, upper_next;
    logic [7:0]  ext0_reg,  ext0_next;
    logic        ers_reg,   ers_next;
    logic        failed_reg, failed_next;
    error_code_t fcode_reg, fcode_next;

    result_t           fifo_reg [FIFO_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;

    result_t    slot [3];
    logic [2:0] slot_vld;
    result_t    res0, res1;
    logic [1:0] push_n;

    logic       accept, pop, nl, fail_now;
    logic [4:0] nib;
    logic [7:0] byte_val;
    logic [8:0] k, d;
    logic [9:0] limit, line_len;
    error_code_t fail_code;

    assign accept = in_valid && !in_stall;
    assign pop    = out_valid && !out_stall;
    assign nl     = (char_code == CHAR_NEWLINE);
    assign nib    = hex_nibble(char_code);
    assign limit  = FIXED_CHARS + {1'b0, cnt_reg, 1'b0};

    always_comb
    begin
        pos_next    = pos_reg;
        pend_next   = pend_reg;
        cnt_next    = cnt_reg;
        raddr_next  = raddr_reg;
        rtype_next  = rtype_reg;
        sum_next    = sum_reg;
        upper_next  = upper_reg;
        ext0_next   = ext0_reg;
        ers_next    = ers_reg;
        failed_next = failed_reg;
        fcode_next  = fcode_reg;
        fail_now    = 1'b0;
        fail_code   = ERR_NONE;
        byte_val    = {pend_reg, nib[3:0]};
        k           = pos_reg[9:1] - 9'd1;
        d           = k - 9'd4;
        line_len    = '0;
        slot_vld    = '0;
        for (int i = 0; i < 3; i++)
        begin
            slot[i] = '{kind: KIND_FAIL, addr: '0, value: '0, code: ERR_NONE, last: 1'b0};
        end

        if (failed_reg)
        begin
            slot_vld[0]  = 1'b1;
            slot[0].code = fcode_reg;
        end
        else
        begin
            // character phase
            if (!nl)
            begin
                if (pos_reg == '0)
                begin
                    if (ers_reg)
                    begin
                        fail_now  = 1'b1;
                        fail_code = ERR_AFTER_EOF;
                    end
                    else if (char_code != CHAR_COLON)
                    begin
                        fail_now  = 1'b1;
                        fail_code = ERR_BAD_START;
                    end
                    else
                    begin
                        cnt_next   = '0;
                        raddr_next = '0;
                        rtype_next = '0;
                        sum_next   = '0;
                        pend_next  = '0;
                        pos_next   = 10'd1;
                    end
                end
                else if (!nib[4])
                begin
                    fail_now  = 1'b1;
                    fail_code = ERR_NON_HEX;
                end
                else if (pos_reg >= 10'd3 && pos_reg >= limit)
                begin
                    fail_now  = 1'b1;
                    fail_code = ERR_LENGTH;
                end
                else
                begin
                    if (pos_reg[0])
                    begin
                        pend_next = nib[3:0];
                    end
                    else
                    begin
                        sum_next = sum_reg + byte_val;
                        if (k == 9'd0)
                        begin
                            cnt_next = byte_val;
                        end
                        else if (k == 9'd1)
                        begin
                            raddr_next = {byte_val, 8'h00};
                        end
                        else if (k == 9'd2)
                        begin
                            raddr_next = {raddr_reg[15:8], byte_val};
                        end
                        else if (k == 9'd3)
                        begin
                            rtype_next = byte_val;
                        end
                        else if (d < {1'b0, cnt_reg})
                        begin
                            if (rtype_reg == REC_DATA)
                            begin
                                slot_vld[0]   = 1'b1;
                                slot[0].kind  = KIND_DATA;
                                slot[0].addr  = {upper_reg, raddr_reg} + 32'(d);
                                slot[0].value = byte_val;
                            end
                            else if (rtype_reg == REC_EXT_LIN)
                            begin
                                if (d == 9'd0)
                                begin
                                    ext0_next = byte_val;
                                end
                                else if (d == 9'd1)
                                begin
                                    upper_next = {ext0_reg, byte_val};
                                end
                            end
                        end
                    end
                    pos_next = pos_reg + 10'd1;
                end
                if (fail_now)
                begin
                    slot_vld[0]  = 1'b1;
                    slot[0].kind = KIND_FAIL;
                    slot[0].code = fail_code;
                end
            end

            // end of line
            if (!fail_now && (nl || end_of_input))
            begin
                line_len = pos_next;
                pos_next = '0;
                if (line_len != '0)
                begin
                    slot_vld[1] = 1'b1;
                    if (line_len != FIXED_CHARS + {1'b0, cnt_next, 1'b0})
                    begin
                        fail_now  = 1'b1;
                        fail_code = ERR_LENGTH;
                    end
                    else if (sum_next != '0)
                    begin
                        fail_now  = 1'b1;
                        fail_code = ERR_CHECKSUM;
                    end
                    else if (rtype_next != REC_DATA && rtype_next != REC_EOF &&
                             rtype_next != REC_EXT_LIN)
                    begin
                        fail_now  = 1'b1;
                        fail_code = ERR_BAD_TYPE;
                    end
                    else if (rtype_next == REC_EXT_LIN && cnt_next < 8'd2)
                    begin
                        fail_now  = 1'b1;
                        fail_code = ERR_SHORT_EXT;
                    end
                    if (fail_now)
                    begin
                        slot[1].code = fail_code;
                    end
                    else
                    begin
                        slot[1].kind = KIND_RECORD;
                        if (rtype_next == REC_EOF)
                        begin
                            ers_next = 1'b1;
                        end
                    end
                end
            end

            // end of input
            if (!fail_now && end_of_input)
            begin
                slot_vld[2] = 1'b1;
                if (ers_next)
                begin
                    slot[2].kind = KIND_FILE;
                end
                else
                begin
                    fail_now     = 1'b1;
                    fail_code    = ERR_NO_EOF;
                    slot[2].code = fail_code;
                end
            end

            if (fail_now)
            begin
                failed_next = 1'b1;
                fcode_next  = fail_code;
            end
        end
    end

    // pack up to two results, mark the last one
    always_comb
    begin
        res0   = slot[0];
        res1   = slot[1];
        push_n = 2'd0;
        if (slot_vld[0])
        begin
            res0 = slot[0];
            if (slot_vld[1])
            begin
                res1   = slot[1];
                push_n = 2'd2;
            end
            else if (slot_vld[2])
            begin
                res1   = slot[2];
                push_n = 2'd2;
            end
            else
            begin
                push_n = 2'd1;
            end
        end
        else if (slot_vld[1])
        begin
            res0 = slot[1];
            if (slot_vld[2])
            begin
                res1   = slot[2];
                push_n = 2'd2;
            end
            else
            begin
                push_n = 2'd1;
            end
        end
        else if (slot_vld[2])
        begin
            res0   = slot[2];
            push_n = 2'd1;
        end
        res0.last = (push_n == 2'd1);
        res1.last = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            pend_reg   <= '0;
            cnt_reg    <= '0;
            raddr_reg  <= '0;
            rtype_reg  <= '0;
            sum_reg    <= '0;
            upper_reg  <= '0;
            ext0_reg   <= '0;
            ers_reg    <= 1'b0;
            failed_reg <= 1'b0;
            fcode_reg  <= ERR_NONE;
        end
        else if (accept)
        begin
            pos_reg    <= pos_next;
            pend_reg   <= pend_next;
            cnt_reg    <= cnt_next;
            raddr_reg  <= raddr_next;
            rtype_reg  <= rtype_next;
            sum_reg    <= sum_next;
            upper_reg  <= upper_next;
            ext0_reg   <= ext0_next;
            ers_reg    <= ers_next;
            failed_reg <= failed_next;
            fcode_reg  <= fcode_next;
        end
    end

    // result queue
    always_ff @(posedge clk)
    begin
        if (accept && push_n != 2'd0)
        begin
            fifo_reg[wr_ptr_reg] <= res0;
            if (push_n == 2'd2)
            begin
                fifo_reg[wr_ptr_reg + PTR_W'(1)] <= res1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (accept)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(push_n);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_reg + (accept ? CNT_W'(push_n) : CNT_W'(0))
                                   - (pop ? CNT_W'(1) : CNT_W'(0));
        end
    end

    assign in_stall     = (count_reg > CNT_W'(FIFO_DEPTH - 2));
    assign out_valid    = (count_reg != '0);
    assign result_kind  = fifo_reg[rd_ptr_reg].kind;
    assign byte_address = fifo_reg[rd_ptr_reg].addr;
    assign byte_value   = fifo_reg[rd_ptr_reg].value;
    assign error_code   = fifo_reg[rd_ptr_reg].code;
    assign last_of_run  = fifo_reg[rd_ptr_reg].last;

endmodule
